/* rtl/ocrm_pkg.sv */
// Package with the register map table, decode types and constants of the control register map.
`default_nettype none
package ocrm_pkg;

	localparam int unsigned DefRegSlots = 64;
	localparam int unsigned EntryW = 6;

	localparam logic [31:0] ReadForce = 32'hE000_0000;
	localparam logic [31:0] WriteForce = 32'hF000_0000;
	localparam logic [31:0] Full = 32'hFFFF_FFFF;
	localparam logic [31:0] VersionWord = 32'h0402_05C1;
	localparam logic [31:0] RefreshWord = 32'h0000_A400;
	localparam logic [31:0] SerialShort = 32'h0000_0060;
	localparam logic [31:0] PortABase = 32'h0000_0300;

	localparam logic [EntryW-1:0] SlotPctra = 6'd33;
	localparam logic [EntryW-1:0] SlotPdtra = 6'd34;

	typedef enum logic [1:0] {
		ST_HANDLED = 2'd0,
		ST_TIMER   = 2'd1,
		ST_DMA     = 2'd2,
		ST_UNMAPPED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		K_RW  = 3'd0,
		K_WO  = 3'd1,
		K_RFC = 3'd2,
		K_PDA = 3'd3,
		K_SFS = 3'd4
	} kind_t;

	typedef struct packed {
		logic              hit;
		logic [EntryW-1:0] slot;
		logic [31:0]       wmask;
		logic [31:0]       wset;
		logic [31:0]       rset;
		kind_t             kind;
		logic              prio;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic              prio;
		logic              mem_wr;
		logic              mem_rd;
		logic [EntryW-1:0] slot;
		logic [31:0]       wdata;
		logic [31:0]       rconst;
	} dec_t;

	function automatic entry_t ent(input logic [EntryW-1:0] slot, input logic [31:0] wmask,
			input logic [31:0] wset, input logic [31:0] rset, input kind_t kind,
			input logic prio);
		entry_t e;
		e.hit = 1'b1;
		e.slot = slot;
		e.wmask = wmask;
		e.wset = wset;
		e.rset = rset;
		e.kind = kind;
		e.prio = prio;
		return e;
	endfunction

	function automatic entry_t lookup(input logic [31:0] a);
		entry_t e;
		e = '{hit: 1'b0, slot: '0, wmask: '0, wset: '0, rset: '0, kind: K_RW, prio: 1'b0};
		case (a)
			32'hFF000000: e = ent(6'd0, 32'hFFFFFCFF, '0, '0, K_RW, 1'b0);
			32'hFF000004: e = ent(6'd1, 32'h1FFFFDFF, '0, '0, K_RW, 1'b0);
			32'hFF000008: e = ent(6'd2, Full, '0, '0, K_RW, 1'b0);
			32'hFF00000C: e = ent(6'd3, Full, '0, '0, K_RW, 1'b0);
			32'hFF000010: e = ent(6'd4, 32'hFCFCFF05, '0, '0, K_RW, 1'b0);
			32'hFF000014: e = ent(6'd5, Full, '0, '0, K_RW, 1'b0);
			32'hFF000018: e = ent(6'd6, Full, '0, '0, K_RW, 1'b0);
			32'hFF00001C: e = ent(6'd7, 32'h000089AF, '0, '0, K_RW, 1'b0);
			32'hFF000020: e = ent(6'd8, 32'h00000FFF, '0, '0, K_RW, 1'b0);
			32'hFF000024: e = ent(6'd9, 32'h000000FF, '0, '0, K_RW, 1'b0);
			32'hFF000028: e = ent(6'd10, 32'h0000FFFF, '0, '0, K_RW, 1'b0);
			32'hFF000034: e = ent(6'd11, 32'h0000000F, '0, '0, K_RW, 1'b0);
			32'hFF000038: e = ent(6'd12, 32'h0000001C, '0, '0, K_RW, 1'b0);
			32'hFF00003C: e = ent(6'd13, 32'h0000001C, '0, '0, K_RW, 1'b0);
			32'hFF000084: e = ent(6'd14, Full, '0, '0, K_RW, 1'b0);
			32'hFF000088: e = ent(6'd15, Full, '0, '0, K_RW, 1'b0);
			32'hFF200000: e = ent(6'd16, Full, '0, '0, K_RW, 1'b0);
			32'hFF200004: e = ent(6'd17, Full, '0, '0, K_RW, 1'b0);
			32'hFF200008: e = ent(6'd18, Full, '0, '0, K_RW, 1'b0);
			32'hFF20000C: e = ent(6'd19, Full, '0, '0, K_RW, 1'b0);
			32'hFF200010: e = ent(6'd20, Full, '0, '0, K_RW, 1'b0);
			32'hFF200014: e = ent(6'd21, Full, '0, '0, K_RW, 1'b0);
			32'hFF200020: e = ent(6'd22, Full, '0, '0, K_RW, 1'b0);
			32'hFF800000: e = ent(6'd23, Full, '0, '0, K_RW, 1'b0);
			32'hFF800004: e = ent(6'd24, Full, '0, '0, K_RW, 1'b0);
			32'hFF800008: e = ent(6'd25, Full, '0, '0, K_RW, 1'b0);
			32'hFF80000C: e = ent(6'd26, Full, '0, '0, K_RW, 1'b0);
			32'hFF800010: e = ent(6'd27, Full, '0, '0, K_RW, 1'b0);
			32'hFF800014: e = ent(6'd28, Full, '0, '0, K_RW, 1'b0);
			32'hFF800018: e = ent(6'd29, Full, '0, '0, K_RW, 1'b0);
			32'hFF80001C: e = ent(6'd30, Full, '0, '0, K_RW, 1'b0);
			32'hFF800024: e = ent(6'd31, Full, '0, '0, K_RW, 1'b0);
			32'hFF800028: e = ent(6'd32, 32'h000001FF, RefreshWord, '0, K_RFC, 1'b0);
			32'hFF80002C: e = ent(6'd33, 32'h0000FFFF, '0, '0, K_RW, 1'b0);
			32'hFF800030: e = ent(6'd34, Full, '0, '0, K_PDA, 1'b0);
			32'hFF800040: e = ent(6'd35, Full, '0, '0, K_RW, 1'b0);
			32'hFF800044: e = ent(6'd36, Full, '0, '0, K_RW, 1'b0);
			32'hFF800048: e = ent(6'd37, Full, '0, '0, K_RW, 1'b0);
			32'hFF940190: e = ent(6'd38, Full, '0, '0, K_RW, 1'b0);
			32'hFFC00000: e = ent(6'd39, Full, '0, '0, K_WO, 1'b0);
			32'hFFC00004: e = ent(6'd40, Full, 32'h3, 32'h3, K_RW, 1'b0);
			32'hFFC00008: e = ent(6'd41, Full, '0, '0, K_WO, 1'b0);
			32'hFFC0000C: e = ent(6'd42, 32'h7F, 32'hA500, 32'hA500, K_RW, 1'b0);
			32'hFFC00010: e = ent(6'd43, Full, '0, '0, K_WO, 1'b0);
			32'hFFC80030: e = ent(6'd44, Full, '0, '0, K_WO, 1'b0);
			32'hFFC80034: e = ent(6'd45, Full, '0, '0, K_RW, 1'b0);
			32'hFFC80038: e = ent(6'd46, 32'h81, '0, '0, K_RW, 1'b0);
			32'hFFC80040: e = ent(6'd47, 32'h80, '0, '0, K_RW, 1'b0);
			32'hFFD00000: e = ent(6'd48, 32'h0000C380, '0, '0, K_RW, 1'b1);
			32'hFFD00004: e = ent(6'd49, 32'h0000FFFF, '0, '0, K_RW, 1'b1);
			32'hFFD00008: e = ent(6'd50, 32'h0000FFF0, '0, '0, K_RW, 1'b1);
			32'hFFD0000C: e = ent(6'd51, 32'h0000FFFF, '0, '0, K_RW, 1'b1);
			32'hFFE80000: e = ent(6'd52, Full, '0, '0, K_RW, 1'b0);
			32'hFFE80004: e = ent(6'd53, Full, '0, '0, K_RW, 1'b0);
			32'hFFE80008: e = ent(6'd54, Full, '0, '0, K_RW, 1'b0);
			32'hFFE8000C: e = ent(6'd55, Full, '0, '0, K_RW, 1'b0);
			32'hFFE80010: e = ent(6'd56, Full, '0, '0, K_SFS, 1'b0);
			32'hFFE80014: e = ent(6'd57, Full, '0, '0, K_RW, 1'b0);
			32'hFFE80018: e = ent(6'd58, Full, '0, '0, K_RW, 1'b0);
			32'hFFE8001C: e = ent(6'd59, Full, '0, '0, K_RW, 1'b0);
			32'hFFE80020: e = ent(6'd60, Full, '0, '0, K_RW, 1'b0);
			32'hFFE80024: e = ent(6'd61, Full, '0, '0, K_RW, 1'b0);
			default: e.hit = 1'b0;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

/* rtl/ocrm_decode.sv */
// Address decode of one transaction into status, store access and read constant.
`default_nettype none
module ocrm_decode
	import ocrm_pkg::*;
(
	input  wire logic        func,
	input  wire logic [31:0] address,
	input  wire logic [2:0]  size_bytes,
	input  wire logic [31:0] write_data,
	input  wire logic [3:0]  pctra_nib,
	input  wire logic [3:0]  pdtra_nib,
	output dec_t             dec
);

	logic [31:0] up_rd;
	logic [31:0] up_wr;
	logic        rd_timer, rd_cache, rd_dma, rd_ccnt;
	logic        wr_timer, wr_cache, wr_dma;
	entry_t      e_rd;
	entry_t      e_wr;
	logic [1:0]  pa_t;

	assign up_rd = address | ReadForce;
	assign up_wr = address | WriteForce;
	assign rd_timer = up_rd >= 32'hFFD8_0000 && up_rd <= 32'hFFD8_002C;
	assign rd_cache = up_rd[31:24] == 8'hF4;
	assign rd_dma = up_rd[31:16] == 16'hFFA0;
	assign rd_ccnt = up_rd == 32'hFF10_0004 || up_rd == 32'hFF10_0008 ||
		up_rd == 32'hFF10_000C || up_rd == 32'hFF10_0010;
	assign wr_timer = up_wr >= 32'hFFD8_0000 && up_wr <= 32'hFFD8_002C;
	assign wr_cache = up_wr[31:24] == 8'hF4 || up_wr[31:24] == 8'hF0;
	assign wr_dma = up_wr[31:16] == 16'hFFA0;
	assign e_rd = lookup(up_rd);
	assign e_wr = lookup(up_wr);

	always_comb begin
		pa_t = (pctra_nib == 4'h8 || pctra_nib == 4'hB) ? 2'd3 : 2'd0;
		if (pctra_nib == 4'hB && pdtra_nib == 4'h2) begin
			pa_t = 2'd0;
		end else if (pctra_nib == 4'hC && pdtra_nib == 4'h2) begin
			pa_t = 2'd3;
		end
	end

	always_comb begin
		dec.status = ST_UNMAPPED;
		dec.prio = 1'b0;
		dec.mem_wr = 1'b0;
		dec.mem_rd = 1'b0;
		dec.slot = e_rd.slot;
		dec.wdata = (write_data & e_wr.wmask) | e_wr.wset;
		dec.rconst = '0;
		if (!func) begin
			if (rd_timer) begin
				dec.status = ST_TIMER;
			end else if (rd_cache) begin
				dec.status = ST_HANDLED;
			end else if (rd_dma) begin
				dec.status = ST_DMA;
			end else if (up_rd == 32'hFF00_0030) begin
				dec.status = ST_HANDLED;
				dec.rconst = VersionWord;
			end else if (rd_ccnt) begin
				dec.status = ST_HANDLED;
			end else if (e_rd.hit) begin
				dec.status = ST_HANDLED;
				unique case (e_rd.kind)
					K_WO: dec.status = ST_UNMAPPED;
					K_RFC: dec.rconst = RefreshWord;
					K_PDA: dec.rconst = PortABase | {30'd0, pa_t};
					K_SFS: begin
						if (size_bytes == 3'd2) begin
							dec.rconst = SerialShort;
						end else begin
							dec.mem_rd = 1'b1;
						end
					end
					default: begin
						dec.mem_rd = 1'b1;
						dec.rconst = e_rd.rset;
					end
				endcase
			end
		end else begin
			dec.slot = e_wr.slot;
			if (wr_dma) begin
				dec.status = ST_DMA;
			end else if (wr_timer) begin
				dec.status = ST_TIMER;
			end else if (wr_cache) begin
				dec.status = ST_HANDLED;
			end else if (e_wr.hit) begin
				dec.status = ST_HANDLED;
				dec.mem_wr = 1'b1;
				dec.prio = e_wr.prio;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/ocrm_store.sv */
// Control word memory with per-slot valid bits and the port A nibble shadows.
`default_nettype none
module ocrm_store
	import ocrm_pkg::*;
#(
	parameter int unsigned REG_SLOTS = DefRegSlots
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic        rd_en,
	input  wire logic [EntryW-1:0] slot,
	input  wire logic [31:0] wdata,
	output logic [31:0]      rdata,
	output logic [3:0]       pctra_nib,
	output logic [3:0]       pdtra_nib
);

	localparam int unsigned SlotW = $clog2(REG_SLOTS);

	logic [31:0]          mem [REG_SLOTS];
	logic [REG_SLOTS-1:0] valid_q;
	logic [SlotW-1:0]     idx;
	logic [31:0]          mem_q;
	logic                 hit_q;
	logic [3:0]           pctra_q;
	logic [3:0]           pdtra_q;

	assign idx = SlotW'(slot);
	assign rdata = hit_q ? mem_q : 32'd0;
	assign pctra_nib = pctra_q;
	assign pdtra_nib = pdtra_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= wdata;
		end
		if (rd_en) begin
			mem_q <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q <= 1'b0;
			pctra_q <= '0;
			pdtra_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[idx] <= 1'b1;
				if (slot == SlotPctra) begin
					pctra_q <= wdata[3:0];
				end
				if (slot == SlotPdtra) begin
					pdtra_q <= wdata[3:0];
				end
			end
			if (rd_en) begin
				hit_q <= valid_q[idx];
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/onchip_control_register_map_core.sv */
// Top level of the on-chip control register map: handshake, stage registers and result register.
//
// The input channel (in_valid, in_stall) carries one bus transaction: func, address,
// size_bytes and write_data. The output channel (out_valid, out_stall) returns one
// result per transaction: read_data, status and priority_changed.
// Results come out in order. From acceptance to out_valid a transaction passes the stage
// registers and then the result register: the accepting edge registers the decode, writes the
// control word memory and reads it into a registered read port; the result register takes
// these when the output advances. Throughput is one transaction per cycle while out_stall is low;
// the single memory port serves the read of each transaction and, on a write, its write too.
// When the receiver stalls, the result register holds, the decode stage fills,
// and in_stall rises while both are occupied.
// Reset clears all control words to zero through per-slot valid bits at once,
// so the block accepts transactions as soon as reset is released.
`default_nettype none
module onchip_control_register_map_core
	import ocrm_pkg::*;
#(
	parameter int unsigned REG_SLOTS = DefRegSlots
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [31:0] address,
	input  wire logic [2:0]  size_bytes,
	input  wire logic [31:0] write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      read_data,
	output logic [1:0]       status,
	output logic             priority_changed
);

	dec_t        dec;
	logic [3:0]  pctra_nib;
	logic [3:0]  pdtra_nib;
	logic [31:0] mem_rdata;
	logic        accept;
	logic        advance;
	logic        valid_s1;
	status_t     status_s1;
	logic        prio_s1;
	logic        mem_s1;
	logic [31:0] rconst_s1;
	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic [1:0]  status_q;
	logic        prio_q;

	ocrm_decode u_decode (
		.func       (func),
		.address    (address),
		.size_bytes (size_bytes),
		.write_data (write_data),
		.pctra_nib  (pctra_nib),
		.pdtra_nib  (pdtra_nib),
		.dec        (dec)
	);

	ocrm_store #(
		.REG_SLOTS (REG_SLOTS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept && dec.mem_wr),
		.rd_en     (accept),
		.slot      (dec.slot),
		.wdata     (dec.wdata),
		.rdata     (mem_rdata),
		.pctra_nib (pctra_nib),
		.pdtra_nib (pdtra_nib)
	);

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status = status_q;
	assign priority_changed = prio_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= dec.status;
			prio_s1 <= dec.prio;
			mem_s1 <= dec.mem_rd;
			rconst_s1 <= dec.rconst;
		end
		if (advance && valid_s1) begin
			read_data_q <= rconst_s1 | (mem_s1 ? mem_rdata : 32'd0);
			status_q <= status_s1;
			prio_q <= prio_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

endmodule
`default_nettype wire
